// File: rtl/x86oh_pkg.sv
// Shared constants, types and helpers for the x86 opcode histogram.
`default_nettype none
package x86oh_pkg;

  localparam int unsigned StoreDepth  = 512;
  localparam int unsigned AddrW       = 9;
  localparam int unsigned CountW      = 32;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned MaxBytesDef = 4;

  localparam logic [ByteW-1:0] EscByte = 8'h0F;

  localparam logic [ByteW-1:0] PfxEs   = 8'h26;
  localparam logic [ByteW-1:0] PfxCs   = 8'h2E;
  localparam logic [ByteW-1:0] PfxSs   = 8'h36;
  localparam logic [ByteW-1:0] PfxDs   = 8'h3E;
  localparam logic [ByteW-1:0] PfxFs   = 8'h64;
  localparam logic [ByteW-1:0] PfxGs   = 8'h65;
  localparam logic [ByteW-1:0] PfxOpsz = 8'h66;
  localparam logic [ByteW-1:0] PfxAdsz = 8'h67;
  localparam logic [ByteW-1:0] PfxLock = 8'hF0;
  localparam logic [ByteW-1:0] PfxRepn = 8'hF2;
  localparam logic [ByteW-1:0] PfxRep  = 8'hF3;

  localparam logic ActCount = 1'b0;
  localparam logic ActRead  = 1'b1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StScan
  } state_e;

  function automatic logic is_prefix(input logic [ByteW-1:0] b);
    logic r;
    r = 1'b0;
    unique case (b)
      PfxEs, PfxCs, PfxSs, PfxDs,
      PfxFs, PfxGs, PfxOpsz, PfxAdsz,
      PfxLock, PfxRepn, PfxRep: r = 1'b1;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/x86oh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module x86oh_ram #(
  parameter int unsigned Width = x86oh_pkg::CountW,
  parameter int unsigned Depth = x86oh_pkg::StoreDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/x86_opcode_histogram.sv
// Top level: x86 opcode byte histogram over a 512-entry counter memory.
//
//   channel  direction  handshake              fields
//   in       sink       in_valid_i/in_stall_o  action_i, instruction_i, index_i
//   out      source     out_valid_o/out_stall_i count_o
//
// A count item scans n bytes (n <= MaxBytes) after it is accepted, one
// read-modify-write per cycle on the counter memory, reads overlapped with
// the write of the previous byte and forwarded when they hit the same entry.
// A read item's counter comes through the RAM's registered read port and is then registered onto count_o.
// After reset a clearing pass zeroes each of the 512 entries in turn; input stalls.
// A read item stalls while a result is stalled or a read is in flight.
`default_nettype none
module x86_opcode_histogram #(
  parameter int unsigned MaxBytes = x86oh_pkg::MaxBytesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           action_i,
  input  wire logic [x86oh_pkg::WordW-1:0]    instruction_i,
  input  wire logic [x86oh_pkg::AddrW-1:0]    index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [x86oh_pkg::CountW-1:0]   count_o
);

  localparam int unsigned AddrW  = x86oh_pkg::AddrW;
  localparam int unsigned CountW = x86oh_pkg::CountW;
  localparam int unsigned WordW  = x86oh_pkg::WordW;
  localparam int unsigned ByteW  = x86oh_pkg::ByteW;
  localparam int unsigned LeftW  = $clog2(MaxBytes + 1);

  x86oh_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]  clr_q, clr_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [WordW-1:0]  word_q, word_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic              fwd_q, fwd_d;
  logic [CountW-1:0] wdata_q, wdata_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q, count_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [CountW-1:0] ram_rdata;

  logic              accept;
  logic [CountW-1:0] cur;
  logic [ByteW-1:0]  cur_byte;
  logic              go_on;
  logic [AddrW-1:0]  next_addr;

  x86oh_ram #(
    .Width (CountW),
    .Depth (x86oh_pkg::StoreDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cur       = fwd_q ? wdata_q : ram_rdata;
    cur_byte  = addr_q[ByteW-1:0];
    go_on     = !addr_q[AddrW-1] && (left_q != '0) &&
                ((cur_byte == x86oh_pkg::EscByte) || x86oh_pkg::is_prefix(cur_byte));
    next_addr = {cur_byte == x86oh_pkg::EscByte, word_q[ByteW-1:0]};

    in_stall_o = (state_q != x86oh_pkg::StIdle) ||
                 ((action_i == x86oh_pkg::ActRead) &&
                  (rd_pend_q || (out_valid_q && out_stall_i)));
    accept     = in_valid_i && !in_stall_o;

    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    word_d      = word_q;
    left_d      = left_q;
    fwd_d       = 1'b0;
    wdata_d     = wdata_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    count_d     = count_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = cur + CountW'(1);
    ram_raddr   = index_i;

    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      count_d     = ram_rdata;
    end

    unique case (state_q)
      x86oh_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = x86oh_pkg::StIdle;
        end
      end
      x86oh_pkg::StIdle: begin
        if (accept) begin
          if (action_i == x86oh_pkg::ActRead) begin
            ram_raddr = index_i;
            rd_pend_d = 1'b1;
          end else begin
            ram_raddr = {1'b0, instruction_i[ByteW-1:0]};
            addr_d    = {1'b0, instruction_i[ByteW-1:0]};
            word_d    = instruction_i >> ByteW;
            left_d    = LeftW'(MaxBytes - 1);
            state_d   = x86oh_pkg::StScan;
          end
        end
      end
      x86oh_pkg::StScan: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = cur + CountW'(1);
        wdata_d   = cur + CountW'(1);
        ram_raddr = next_addr;
        if (go_on) begin
          fwd_d  = (next_addr == addr_q);
          addr_d = next_addr;
          word_d = word_q >> ByteW;
          left_d = left_q - LeftW'(1);
        end else begin
          state_d = x86oh_pkg::StIdle;
        end
      end
      default: begin
        state_d = x86oh_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= x86oh_pkg::StClear;
      clr_q       <= '0;
      fwd_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fwd_q       <= fwd_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    word_q  <= word_d;
    left_q  <= left_d;
    wdata_q <= wdata_d;
    count_q <= count_d;
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != x86oh_pkg::StIdle))
    else $error("counter write while idle");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == x86oh_pkg::StClear) |-> in_stall_o)
    else $error("input accepted during clearing pass");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(rd_pend_q))
    else $error("result without a pending read");

  a_fwd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (state_q == x86oh_pkg::StScan))
    else $error("forwarding flag outside scan");

endmodule
`default_nettype wire

// File: bench/x86_opcode_histogram_test.sv
// Self-checking testbench for the x86 opcode histogram: counts words, reads back counters.
`default_nettype none
module x86_opcode_histogram_test;
  import x86oh_pkg::*;

  class histogram_model;
    bit [CountW-1:0]  tally [StoreDepth];
    bit [CountW-1:0]  expected_counts [$];
    logic [AddrW-1:0] touched [$];
    int errors;
    int words_counted;
    int reads_seen;
    int results_checked;

    function bit prefix_byte(logic [ByteW-1:0] b);
      case (b)
        PfxEs, PfxCs, PfxSs, PfxDs, PfxFs, PfxGs,
        PfxOpsz, PfxAdsz, PfxLock, PfxRepn, PfxRep: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void bump(logic [AddrW-1:0] slot);
      tally[slot] = tally[slot] + 1;
      touched.push_back(slot);
      if (touched.size() > 32) void'(touched.pop_front());
    endfunction

    // accepted item: a read snapshots its counter, a count word updates the tally
    function void note_item(logic act, logic [WordW-1:0] word, logic [AddrW-1:0] idx);
      logic [63:0]      rest;
      logic [ByteW-1:0] b;
      bit               escaped;
      int               n;
      if (act == ActRead) begin
        expected_counts.push_back(tally[idx]);
        reads_seen++;
        return;
      end
      words_counted++;
      rest = {32'b0, word};
      escaped = 1'b0;
      for (n = 0; n < MaxBytesDef; n++) begin
        b = rest[7:0];
        rest = rest >> 8;
        if (escaped) begin
          bump({1'b1, b});
          return;
        end
        bump({1'b0, b});
        if (b == EscByte) begin
          escaped = 1'b1;
        end else if (!prefix_byte(b)) begin
          return;
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    task check_count(logic [CountW-1:0] got);
      bit [CountW-1:0] want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("count %h arrived with no read pending", got));
        return;
      end
      want = expected_counts.pop_front();
      results_checked++;
      if (got !== want)
        report_mismatch($sformatf("read %0d: count %h, want %h", results_checked, got, want));
    endtask

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                action_i;
  logic [WordW-1:0]    instruction_i;
  logic [AddrW-1:0]    index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CountW-1:0]   count_o;

  histogram_model board = new();
  bit steady;
  int hold_req;
  int hold_left;
  logic [ByteW-1:0] prefix_set [0:10] = '{PfxEs, PfxCs, PfxSs, PfxDs, PfxFs, PfxGs,
                                         PfxOpsz, PfxAdsz, PfxLock, PfxRepn, PfxRep};

  x86_opcode_histogram u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .instruction_i (instruction_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_o       (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4800000;
    $display("Mismatches found");
    $finish;
  end

  // result side: check, then pick the stall for the next cycle
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_count(count_o);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 19);
      end
    end
  end

  task automatic send_item(logic act, logic [WordW-1:0] word, logic [AddrW-1:0] idx);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    instruction_i <= word;
    index_i       <= idx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(act, word, idx);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() > 0);
  endtask

  // prefixes, then an escape or an opcode, random trailing bytes
  function automatic logic [WordW-1:0] shaped_word();
    logic [WordW-1:0] w;
    int               npfx;
    int               k;
    w = $urandom;
    npfx = $urandom_range(0, 3);
    for (k = 0; k < npfx; k++) w[8*k +: 8] = prefix_set[$urandom_range(10)];
    if ($urandom_range(99) < 35) w[8*npfx +: 8] = EscByte;
    return w;
  endfunction

  function automatic logic [AddrW-1:0] pick_index();
    if (board.touched.size() > 0 && $urandom_range(99) < 60)
      return board.touched[$urandom_range(board.touched.size() - 1)];
    return AddrW'($urandom_range(StoreDepth - 1));
  endfunction

  initial begin
    int i;
    int w;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ActCount;
    instruction_i = '0;
    index_i       = '0;
    steady        = 1'b0;
    hold_req      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh store, field extremes, prefix chains, escapes
    send_item(ActRead,  32'hFFFF_FFFF, 9'd0);
    send_item(ActRead,  32'h0000_0000, 9'd511);
    send_item(ActCount, 32'h0000_0000, 9'h1FF);
    send_item(ActCount, 32'hFFFF_FFFF, 9'h000);
    send_item(ActCount, 32'h0000_0090, 9'h155);
    send_item(ActCount, 32'h66F3_F026, 9'h0AA);
    send_item(ActCount, 32'h672E_3E36, 9'h1FF);
    send_item(ActCount, 32'h9064_F265, 9'h000);
    send_item(ActCount, 32'hFFFF_050F, 9'h1FF);
    send_item(ActCount, 32'h0F66_F3F0, 9'h000);   // escape as last scanned byte
    send_item(ActCount, 32'h0000_0F0F, 9'h1FF);
    send_item(ActCount, 32'h0066_0F66, 9'h000);
    send_item(ActRead,  32'hFFFF_FFFF, 9'd0);
    send_item(ActRead,  32'h0000_0000, 9'd255);
    send_item(ActRead,  32'hFFFF_FFFF, 9'h00F);
    send_item(ActRead,  32'h0000_0000, 9'h105);
    send_item(ActRead,  32'hFFFF_FFFF, 9'h10F);
    send_item(ActRead,  32'h0000_0000, 9'h166);
    send_item(ActRead,  32'hFFFF_FFFF, 9'h066);
    send_item(ActRead,  32'h0000_0000, 9'h026);
    send_item(ActRead,  32'hFFFF_FFFF, 9'h090);
    send_item(ActRead,  32'h0000_0000, 9'd511);
    send_item(ActRead,  32'hFFFF_FFFF, 9'd256);

    for (i = 0; i < 1930; i++) begin
      steady = (i >= 700 && i < 1000);
      if (i == 400) hold_req = 300;
      if (i == 1200 || i == 1600) drain_results();
      if ($urandom_range(99) < 40)
        send_item(ActRead, $urandom, pick_index());
      else if ($urandom_range(99) < 75)
        send_item(ActCount, shaped_word(), AddrW'($urandom));
      else
        send_item(ActCount, $urandom, AddrW'($urandom));
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    for (w = 0; w < 20000 && board.pending() > 0; w++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (board.pending() > 0)
      board.report_mismatch($sformatf("%0d reads never answered", board.pending()));

    $display("Run covered %0d counted words and %0d counter reads, %0d results checked.",
             board.words_counted, board.reads_seen, board.results_checked);
    $display("It included a 300-cycle output hold-off and two full drains of pending reads.");
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
